### rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

### rtl/rrict_pkg.sv
// Types, constants and helper functions for the run/idle cycle timer.
package rrict_pkg;

    localparam int YEAR_W   = 12;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;

    localparam int SOD_W    = 11;
    localparam int REP_W    = 5;
    localparam int LEN_W    = 6;
    localparam int MODE_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    localparam int STATUS_W = 2;
    localparam int LEFT_W   = 16;
    localparam int TOTAL_W  = 32;
    localparam int START_W  = 31;
    localparam int DAYS_W   = 21;
    localparam int SMALL_W  = 14;
    localparam int DIFF_W   = 34;
    localparam int REM_W    = 35;

    localparam int MIN_PER_YEAR  = 525600;
    localparam int MIN_PER_MONTH = 43800;
    localparam int MIN_PER_DAY   = 1440;
    localparam int MIN_PER_HOUR  = 60;
    localparam int DAY_PER_YEAR  = 365;
    localparam int DAY_PER_MONTH = 30;
    localparam int MONTH_REM_MIN = MIN_PER_MONTH - DAY_PER_MONTH * MIN_PER_DAY;

    localparam int RECIP_60       = 2185;
    localparam int RECIP_60_SHIFT = 17;

    localparam logic [SOD_W-1:0]  RST_START_SOD = SOD_W'(1260);
    localparam logic [REP_W-1:0]  RST_REPEATS   = REP_W'(1);
    localparam logic [LEN_W-1:0]  RST_RUN_LEN   = LEN_W'(15);
    localparam logic [LEN_W-1:0]  RST_IDLE_LEN  = LEN_W'(30);
    localparam logic [DAY_W-1:0]  RST_LAST_DAY  = DAY_W'(1);
    localparam logic [MONTH_W-1:0] RST_LAST_MON = MONTH_W'(1);
    localparam logic [YEAR_W-1:0] RST_LAST_YEAR = YEAR_W'(2022);

    typedef enum logic [STATUS_W-1:0] {
        ST_STOPPED = 2'd0,
        ST_RUNNING = 2'd1,
        ST_WAITING = 2'd2
    } t_status;

    typedef enum logic [MODE_W-1:0] {
        MODE_OFF   = 2'd0,
        MODE_DAILY = 2'd1,
        MODE_SKIP2 = 2'd2,
        MODE_SKIP3 = 2'd3
    } t_day_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_SOD  = 3'd0,
        CFG_REPEATS    = 3'd1,
        CFG_RUN_LEN    = 3'd2,
        CFG_IDLE_LEN   = 3'd3,
        CFG_DAY_MODE   = 3'd4,
        CFG_LAST_DAY   = 3'd5,
        CFG_LAST_MONTH = 3'd6,
        CFG_LAST_YEAR  = 3'd7
    } t_cfg_idx;

    // Whole days in a small leftover minute count (below eight days).
    function automatic logic [2:0] f_small_days(input logic [SMALL_W-1:0] s);
        logic [2:0] q;
        q = 3'd0;
        for (int k = 1; k < 8; k++) begin
            if (s >= SMALL_W'(k * MIN_PER_DAY)) begin
                q = 3'(k);
            end
        end
        return q;
    endfunction

    // Day count of a date, matching the minute count divided by a day.
    function automatic logic [DAYS_W-1:0] f_day_count(
        input logic [YEAR_W-1:0]   y,
        input logic [MONTH_W-1:0]  mo,
        input logic [DAY_W-1:0]    d,
        input logic [SMALL_W-1:0]  part_min
    );
        logic [SMALL_W-1:0] s;
        s = SMALL_W'(mo) * SMALL_W'(MONTH_REM_MIN) + part_min;
        return DAYS_W'(y) * DAYS_W'(DAY_PER_YEAR) + DAYS_W'(d)
            + DAYS_W'(mo) * DAYS_W'(DAY_PER_MONTH) + DAYS_W'(f_small_days(s));
    endfunction

    function automatic logic signed [LEFT_W-1:0] f_sat16(input logic signed [REM_W-1:0] v);
        logic signed [REM_W-1:0] hi;
        logic signed [REM_W-1:0] lo;
        hi = REM_W'(32767);
        lo = -REM_W'(32768);
        if (v > hi) begin
            return LEFT_W'(32767);
        end else if (v < lo) begin
            return LEFT_W'(16'h8000);
        end
        return v[LEFT_W-1:0];
    endfunction

endpackage

### rtl/repeating_run_idle_cycle_timer_top.sv
// Run/idle cycle timer: date/time ticks in, one status result out per tick.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one real-time tick per
//   transaction: year, month, day, hour and minute. Output channel
//   (o_out_valid / i_out_ready) returns one result per tick: status after
//   the tick, task flag, delayed status-change report and remaining counts.
//   Configuration registers are written through i_cfg_we / i_cfg_idx /
//   i_cfg_wdata while no tick is in flight; each write takes effect at once.
//   Path: an accepted tick waits in the input register; its result is then
//   written to the result register that also holds the state.
//   Throughput: one tick per cycle while the receiver takes results; the
//   whole step is one combinational pass of constant multiplies, one small
//   multiply and compares between the two registers.
//   Stall: while the receiver holds i_out_ready low, the result is kept and
//   one more tick is taken into the input register; after that o_in_ready
//   drops until the result is taken.
//   Reset (i_rst_n low, synchronous): both channels empty, state stopped,
//   configuration back to its defaults.
`include "assert_macros.svh"

module repeating_run_idle_cycle_timer_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [rrict_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [rrict_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [rrict_pkg::YEAR_W-1:0]          i_now_year,
    input  logic [rrict_pkg::MONTH_W-1:0]         i_now_month,
    input  logic [rrict_pkg::DAY_W-1:0]           i_now_day,
    input  logic [rrict_pkg::HOUR_W-1:0]          i_now_hour,
    input  logic [rrict_pkg::MINUTE_W-1:0]        i_now_minute,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [rrict_pkg::STATUS_W-1:0]        o_cycle_status,
    output logic                                  o_output_active,
    output logic                                  o_status_changed,
    output logic [rrict_pkg::STATUS_W-1:0]        o_reported_status,
    output logic signed [rrict_pkg::LEFT_W-1:0]   o_run_left,
    output logic signed [rrict_pkg::LEFT_W-1:0]   o_idle_left,
    output logic [rrict_pkg::REP_W-1:0]           o_repeats_left
);
    import rrict_pkg::*;

    // Configuration
    logic [SOD_W-1:0]   r_start_sod;
    logic [REP_W-1:0]   r_repeat_total;
    logic [LEN_W-1:0]   r_run_len;
    logic [LEN_W-1:0]   r_idle_len;
    t_day_mode          r_day_mode;
    logic [DAY_W-1:0]   r_last_day;
    logic [MONTH_W-1:0] r_last_month;
    logic [YEAR_W-1:0]  r_last_year;

    // Input register
    logic                r_in_vld;
    logic [YEAR_W-1:0]   r_year;
    logic [MONTH_W-1:0]  r_month;
    logic [DAY_W-1:0]    r_day;
    logic [HOUR_W-1:0]   r_hour;
    logic [MINUTE_W-1:0] r_minute;

    // Result register and cycle state
    logic                     r_out_vld;
    t_status                  r_status;
    t_status                  r_last_rep;
    logic                     r_active;
    logic [START_W-1:0]       r_start;
    logic [REP_W-1:0]         r_repeats;
    logic signed [LEFT_W-1:0] r_run_left;
    logic signed [LEFT_W-1:0] r_idle_left;
    logic                     r_changed;
    t_status                  r_reported;

    t_status                  n_status;
    logic                     n_active;
    logic [START_W-1:0]       n_start;
    logic [REP_W-1:0]         n_repeats;
    logic signed [LEFT_W-1:0] n_run_left;
    logic signed [LEFT_W-1:0] n_idle_left;

    logic                     adv;
    logic [SOD_W+12-1:0]      hr_prod;
    logic [MINUTE_W-1:0]      alarm_hr;
    logic [SOD_W-1:0]         alarm_min_full;
    logic [MINUTE_W-1:0]      alarm_min;
    logic [TOTAL_W-1:0]       now_total;
    logic [SMALL_W-1:0]       now_part;
    logic [DAYS_W-1:0]        now_days;
    logic [DAYS_W-1:0]        last_days;
    logic signed [DAYS_W:0]   diff_days;
    logic                     gate;
    logic                     trig;
    logic [LEN_W:0]           period;
    logic signed [REP_W:0]    elapsed;
    logic signed [SMALL_W-1:0] offset;
    logic signed [DIFF_W-1:0] base;
    logic signed [DIFF_W-1:0] diff;
    logic signed [REM_W-1:0]  rem_run;
    logic signed [REM_W-1:0]  rem_idle;

    assign adv        = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || adv;

    // Start time split into hour and minute by reciprocal multiply.
    assign hr_prod        = (SOD_W+12)'(r_start_sod) * (SOD_W+12)'(RECIP_60);
    assign alarm_hr       = hr_prod[RECIP_60_SHIFT +: MINUTE_W];
    assign alarm_min_full = r_start_sod - SOD_W'(alarm_hr) * SOD_W'(MIN_PER_HOUR);
    assign alarm_min      = alarm_min_full[MINUTE_W-1:0];

    assign now_total = TOTAL_W'(r_year) * TOTAL_W'(MIN_PER_YEAR)
                     + TOTAL_W'(r_month) * TOTAL_W'(MIN_PER_MONTH)
                     + TOTAL_W'(r_day) * TOTAL_W'(MIN_PER_DAY)
                     + TOTAL_W'(r_hour) * TOTAL_W'(MIN_PER_HOUR)
                     + TOTAL_W'(r_minute);

    assign now_part  = SMALL_W'(r_hour) * SMALL_W'(MIN_PER_HOUR) + SMALL_W'(r_minute);
    assign now_days  = f_day_count(r_year, r_month, r_day, now_part);
    assign last_days = f_day_count(r_last_year, r_last_month, r_last_day, '0);
    assign diff_days = $signed({1'b0, now_days}) - $signed({1'b0, last_days});

    always_comb begin
        case (r_day_mode)
            MODE_DAILY: gate = 1'b1;
            MODE_SKIP2: gate = diff_days > (DAYS_W+1)'(2);
            MODE_SKIP3: gate = diff_days > (DAYS_W+1)'(3);
            default:    gate = 1'b0;
        endcase
    end

    assign trig = gate && (r_minute == alarm_min) && ({1'b0, r_hour} == alarm_hr);

    always_comb begin
        n_status    = r_status;
        n_active    = r_active;
        n_start     = r_start;
        n_repeats   = r_repeats;
        n_run_left  = r_run_left;
        n_idle_left = r_idle_left;
        if (trig) begin
            n_status    = ST_RUNNING;
            n_active    = 1'b1;
            n_start     = now_total[START_W-1:0];
            n_repeats   = r_repeat_total;
            n_run_left  = LEFT_W'(r_run_len);
            n_idle_left = LEFT_W'(r_idle_len);
        end

        period   = (LEN_W+1)'(r_run_len) + (LEN_W+1)'(r_idle_len);
        elapsed  = $signed({1'b0, r_repeat_total}) - $signed({1'b0, n_repeats});
        offset   = $signed({1'b0, period}) * elapsed;
        base     = $signed({3'b0, n_start}) + DIFF_W'(offset);
        diff     = $signed({2'b0, now_total}) - base;
        rem_run  = $signed({{(REM_W-LEN_W){1'b0}}, r_run_len}) - REM_W'(diff);
        rem_idle = $signed({{(REM_W-LEN_W-1){1'b0}}, period}) - REM_W'(diff);

        if (gate) begin
            unique case (n_status)
                ST_RUNNING: begin
                    n_run_left = f_sat16(rem_run);
                    if (rem_run == '0) begin
                        n_status = ST_WAITING;
                    end
                end
                ST_WAITING: begin
                    n_idle_left = f_sat16(rem_idle);
                    if (rem_idle == '0) begin
                        if (n_repeats > REP_W'(1)) begin
                            n_repeats   = n_repeats - REP_W'(1);
                            n_status    = ST_RUNNING;
                            n_run_left  = LEFT_W'(r_run_len);
                            n_idle_left = LEFT_W'(r_idle_len);
                        end else begin
                            n_status = ST_STOPPED;
                            n_active = 1'b0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_sod    <= RST_START_SOD;
            r_repeat_total <= RST_REPEATS;
            r_run_len      <= RST_RUN_LEN;
            r_idle_len     <= RST_IDLE_LEN;
            r_day_mode     <= MODE_DAILY;
            r_last_day     <= RST_LAST_DAY;
            r_last_month   <= RST_LAST_MON;
            r_last_year    <= RST_LAST_YEAR;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_START_SOD:  r_start_sod    <= i_cfg_wdata[SOD_W-1:0];
                CFG_REPEATS:    r_repeat_total <= i_cfg_wdata[REP_W-1:0];
                CFG_RUN_LEN:    r_run_len      <= i_cfg_wdata[LEN_W-1:0];
                CFG_IDLE_LEN:   r_idle_len     <= i_cfg_wdata[LEN_W-1:0];
                CFG_DAY_MODE:   r_day_mode     <= t_day_mode'(i_cfg_wdata[MODE_W-1:0]);
                CFG_LAST_DAY:   r_last_day     <= i_cfg_wdata[DAY_W-1:0];
                CFG_LAST_MONTH: r_last_month   <= i_cfg_wdata[MONTH_W-1:0];
                CFG_LAST_YEAR:  r_last_year    <= i_cfg_wdata[YEAR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_year   <= i_now_year;
            r_month  <= i_now_month;
            r_day    <= i_now_day;
            r_hour   <= i_now_hour;
            r_minute <= i_now_minute;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld    <= 1'b0;
            r_out_vld   <= 1'b0;
            r_status    <= ST_STOPPED;
            r_last_rep  <= ST_STOPPED;
            r_active    <= 1'b0;
            r_start     <= '0;
            r_repeats   <= '0;
            r_run_left  <= '0;
            r_idle_left <= '0;
            r_changed   <= 1'b0;
            r_reported  <= ST_STOPPED;
        end else begin
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (adv) begin
                r_out_vld   <= 1'b1;
                r_status    <= n_status;
                r_last_rep  <= r_status;
                r_active    <= n_active;
                r_start     <= n_start;
                r_repeats   <= n_repeats;
                r_run_left  <= n_run_left;
                r_idle_left <= n_idle_left;
                r_changed   <= (r_last_rep != r_status);
                r_reported  <= (r_last_rep != r_status) ? r_status : ST_STOPPED;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_out_valid       = r_out_vld;
    assign o_cycle_status    = r_status;
    assign o_output_active   = r_active;
    assign o_status_changed  = r_changed;
    assign o_reported_status = r_reported;
    assign o_run_left        = r_run_left;
    assign o_idle_left       = r_idle_left;
    assign o_repeats_left    = r_repeats;

    `ASSERT_CLK(a_active_matches_status, i_clk, i_rst_n, r_active == (r_status != ST_STOPPED), "task flag disagrees with cycle status")
    `ASSERT_CLK(a_report_zero_when_quiet, i_clk, i_rst_n, r_changed || (r_reported == ST_STOPPED), "reported status set without a change")
    `ASSERT_NEXT(a_report_tracks_status, i_clk, i_rst_n, adv, r_last_rep == $past(r_status), "last reported status lost")
    `ASSERT_NEXT(a_result_follows_advance, i_clk, i_rst_n, adv, r_out_vld, "advanced transaction has no result")

endmodule
